@@ hw/rtl/base64_stream_encoder_unit_defines.svh @@
// Assertion macros for the base64 stream encoder.
// Depends on nothing; included by the top level.
`ifndef BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication under reset.
`define B64SE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under reset.
`define B64SE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/b64se_pkg.sv @@
// Types, constants and the character map of the base64 stream encoder.
// No dependencies.
package b64se_pkg;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_THIRD
	} b64se_phase_t;

	localparam logic [7:0] CH_PAD       = 8'h3D;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] OFS_UPPER    = 8'd65;
	localparam logic [7:0] OFS_LOWER    = 8'd71;
	localparam logic [7:0] OFS_DIGIT    = 8'd4;

	typedef struct packed {
		logic       pad;
		logic [5:0] code;
	} b64se_slot_t;

	typedef struct packed {
		b64se_slot_t [3:0] slot;
		logic [1:0]        last;
		logic              fin;
	} b64se_entry_t;

	typedef struct packed {
		logic         valid;
		b64se_entry_t entry;
	} b64se_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} b64se_fifo_stat_t;

	function automatic logic [7:0] b64se_ascii(b64se_slot_t s);
		logic [7:0] c;
		logic [7:0] r;
		c = {2'b00, s.code};
		case (s.code) inside
			[6'd0:6'd25]:  r = c + OFS_UPPER;
			[6'd26:6'd51]: r = c + OFS_LOWER;
			[6'd52:6'd61]: r = c - OFS_DIGIT;
			6'd62:         r = CH_PLUS;
			default:       r = CH_SLASH;
		endcase
		if (s.pad) begin
			r = CH_PAD;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/b64se_byte_if.sv @@
// Valid/ready channel that carries raw message bytes.
// No dependencies.
interface b64se_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ hw/rtl/b64se_char_if.sv @@
// Valid/ready channel that carries encoded characters.
// No dependencies.
interface b64se_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       final_char;

	modport source (output valid, output text_char, output final_char, input ready);
	modport sink (input valid, input text_char, input final_char, output ready);
endinterface

@@ hw/rtl/b64se_front.sv @@
// Front end: accepts bytes, tracks the group phase and builds a character group.
// Depends on b64se_pkg and b64se_byte_if.
module b64se_front (
	input  logic                       clk,
	input  logic                       arst_n,
	b64se_byte_if.sink                 raw,
	input  b64se_pkg::b64se_fifo_stat_t fifo_stat,
	output b64se_pkg::b64se_push_t     push,
	output b64se_pkg::b64se_phase_t    phase
);
	import b64se_pkg::*;

	b64se_phase_t phase_q, phase_d;
	logic [3:0]   left_q, left_d;
	b64se_entry_t ent;
	logic         accept;
	logic [7:0]   b;

	assign raw.ready = !fifo_stat.full;
	assign accept    = raw.valid && raw.ready;
	assign b         = raw.data_byte;
	assign phase     = phase_q;

	always_comb begin
		ent     = '0;
		ent.fin = raw.final_byte;
		phase_d = phase_q;
		left_d  = left_q;
		case (phase_q)
			PH_SECOND: begin
				ent.slot[0].code = {left_q[1:0], b[7:4]};
				if (raw.final_byte) begin
					ent.slot[1].code = {b[3:0], 2'b00};
					ent.slot[2].pad  = 1'b1;
					ent.last         = 2'd2;
					phase_d          = PH_FIRST;
					left_d           = 4'd0;
				end else begin
					ent.last = 2'd0;
					phase_d  = PH_THIRD;
					left_d   = b[3:0];
				end
			end
			PH_THIRD: begin
				ent.slot[0].code = {left_q, b[7:6]};
				ent.slot[1].code = b[5:0];
				ent.last         = 2'd1;
				phase_d          = PH_FIRST;
				left_d           = 4'd0;
			end
			default: begin
				ent.slot[0].code = b[7:2];
				if (raw.final_byte) begin
					ent.slot[1].code = {b[1:0], 4'b0000};
					ent.slot[2].pad  = 1'b1;
					ent.slot[3].pad  = 1'b1;
					ent.last         = 2'd3;
					phase_d          = PH_FIRST;
					left_d           = 4'd0;
				end else begin
					ent.last = 2'd0;
					phase_d  = PH_SECOND;
					left_d   = {2'b00, b[1:0]};
				end
			end
		endcase
	end

	assign push.valid = accept;
	assign push.entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			left_q  <= 4'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end
endmodule

@@ hw/rtl/b64se_fifo.sv @@
// Short queue of character groups between front and back end.
// Depends on b64se_pkg. DEPTH must be a power of two.
module b64se_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  b64se_pkg::b64se_push_t      push,
	input  logic                        pop,
	output b64se_pkg::b64se_entry_t     rd_entry,
	output b64se_pkg::b64se_fifo_stat_t stat
);
	import b64se_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	b64se_entry_t  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_pop     = pop && !stat.empty;
	assign rd_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({push.valid, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

@@ hw/rtl/b64se_back.sv @@
// Back end: drains character groups one character per cycle, while text.ready allows, into an output register.
// Depends on b64se_pkg and b64se_char_if.
module b64se_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  b64se_pkg::b64se_entry_t     rd_entry,
	input  b64se_pkg::b64se_fifo_stat_t fifo_stat,
	output logic                        pop,
	b64se_char_if.source                text
);
	import b64se_pkg::*;

	b64se_entry_t cur_q;
	logic         cur_valid_q;
	logic [1:0]   idx_q;
	logic         out_valid_q;
	logic [7:0]   char_q;
	logic         fin_q;
	logic         adv;
	logic         at_last;

	assign at_last = (idx_q == cur_q.last);
	assign adv     = cur_valid_q && (!out_valid_q || text.ready);
	assign pop     = !fifo_stat.empty && (!cur_valid_q || (adv && at_last));

	assign text.valid      = out_valid_q;
	assign text.text_char  = char_q;
	assign text.final_char = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				idx_q <= 2'd0;
			end else if (adv) begin
				idx_q <= idx_q + 2'd1;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (adv && at_last) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd_entry;
		end
		if (adv) begin
			char_q <= b64se_ascii(cur_q.slot[idx_q]);
			fin_q  <= cur_q.fin && at_last;
		end
	end
endmodule

@@ hw/rtl/base64_stream_encoder_unit.sv @@
// Base64 stream encoder: one raw byte in, base64 characters out (standard alphabet, '=' pad).
// Path: a byte's group passes the queue, the back end's current-group register and char_q.
// Throughput: one character per cycle out while text.ready is high; a byte every cycle while
// the group queue has room; sustained, the back end's single character output sets the pace.
// Reset: arst_n clears group phase, leftover bits, the queue and the output valid.
// Depends on b64se_pkg, the channel interfaces, front, queue and back modules.
module base64_stream_encoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	b64se_byte_if.sink    raw,
	b64se_char_if.source  text
);
	import b64se_pkg::*;
	`include "base64_stream_encoder_unit_defines.svh"

	b64se_push_t      push;
	b64se_fifo_stat_t fifo_stat;
	b64se_entry_t     rd_entry;
	b64se_phase_t     phase;
	logic             pop;

	b64se_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw       (raw),
		.fifo_stat (fifo_stat),
		.push      (push),
		.phase     (phase)
	);

	b64se_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.rd_entry (rd_entry),
		.stat     (fifo_stat)
	);

	b64se_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_entry  (rd_entry),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.text      (text)
	);

	`B64SE_ASSERT_NOW(a_no_overflow, clk, arst_n, push.valid, !fifo_stat.full, "push into full queue")
	`B64SE_ASSERT_NEXT(a_final_resets, clk, arst_n, raw.valid && raw.ready && raw.final_byte, phase == PH_FIRST, "phase not cleared after final byte")
	`B64SE_ASSERT_NEXT(a_push_lands, clk, arst_n, push.valid, !fifo_stat.empty, "queue empty after push")
endmodule
